@@ hw/rtl/maf_pkg.sv @@
// shared constants and codes for the moving average filter
`default_nettype none

package maf_pkg;

    localparam int MAX_PERIOD_DEF   = 256;
    localparam int SAMPLE_WIDTH_DEF = 32;

    localparam int PERIOD_W   = 9;
    localparam int METHOD_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam int OUT_W      = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(14);

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_METHOD = 1'b1;

    localparam logic [METHOD_W-1:0] METH_SMA  = 2'd0;
    localparam logic [METHOD_W-1:0] METH_EMA  = 2'd1;
    localparam logic [METHOD_W-1:0] METH_SMMA = 2'd2;
    localparam logic [METHOD_W-1:0] METH_LWMA = 2'd3;

    localparam logic [METHOD_W-1:0] METHOD_RST = METH_SMA;

endpackage

`default_nettype wire

@@ hw/rtl/maf_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module maf_div #(
    parameter int DIVIDEND_W = 48,
    parameter int DIVISOR_W  = 16,
    parameter int QUOT_W     = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [QUOT_W-1:0]          o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_num;
    logic [DIVISOR_W-1:0]  r_den;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [QUOT_W-1:0]     r_quo;

    logic [DIVISOR_W:0]    w_trial;
    logic                  w_ge;
    logic [DIVISOR_W:0]    w_diff;
    logic [DIVISOR_W-1:0]  n_rem;

    always_comb begin
        w_trial = {r_rem, r_num[DIVIDEND_W-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
        n_rem   = w_ge ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= n_rem;
            r_quo <= {r_quo[QUOT_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

@@ hw/rtl/moving_average_filter.sv @@
// moving average filter top level: window ring, running sums, sequencer
// sequence from input transfer to result: window read and write, sum update, setup,
// serial division when one is needed (none when not yet valid, ema seed), output load;
// the next input transfer is taken only after the result is loaded, so one sample is
// in flight at a time; a held output delays it
// reset: synchronous active low; period 14, simple method, history cleared,
// window contents left as they are
`default_nettype none

module moving_average_filter #(
    parameter int MAX_PERIOD   = maf_pkg::MAX_PERIOD_DEF,
    parameter int SAMPLE_WIDTH = maf_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [maf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [maf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,   // sample
    input  wire logic                                s_axis_tuser,   // restart
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [maf_pkg::OUT_W-1:0]                m_axis_tdata,   // average
    output logic                                     m_axis_tuser    // valid_res
);

    import maf_pkg::*;

    localparam int SW  = SAMPLE_WIDTH;
    localparam int EPW = $clog2(MAX_PERIOD + 1);
    localparam int AW  = $clog2(MAX_PERIOD);
    localparam int RSW = SW + $clog2(MAX_PERIOD);
    localparam int WSW = SW + $clog2(MAX_PERIOD * (MAX_PERIOD + 1) / 2);
    localparam int DVW = $clog2(MAX_PERIOD * (MAX_PERIOD + 1) / 2 + 1);
    localparam int MW  = SW + EPW;
    localparam int CW  = (EPW > PERIOD_W) ? EPW : PERIOD_W;
    localparam int IW  = EPW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_PREP = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]          r_state;
    logic [PERIOD_W-1:0] r_period;
    logic [METHOD_W-1:0] r_method;
    logic [SW-1:0]       r_x;
    logic                r_full;
    logic                r_empty;
    logic                r_valid;
    logic [SW-1:0]       r_oldest;
    logic [MW-1:0]       r_prod;
    logic [AW-1:0]       r_wr_pos;
    logic [EPW-1:0]      r_seen;
    logic [RSW-1:0]      r_run;
    logic [WSW-1:0]      r_wsum;
    logic [SW-1:0]       r_last;
    logic [SW-1:0]       r_res;
    logic                r_res_vld;
    logic                r_ovalid;
    logic [OUT_W-1:0]    r_odata;
    logic                r_ovld;
    logic [SW-1:0]       r_win [MAX_PERIOD];

    logic [CW-1:0]       w_per_ext;
    logic [EPW-1:0]      p_eff;
    logic                w_accept;
    logic                w_cfg_hit;
    logic                w_full_now;
    logic [IW-1:0]       w_wp_ext;
    logic [IW-1:0]       w_idx_ext;
    logic [AW-1:0]       w_rd_idx;
    logic [AW-1:0]       n_wr_pos;
    logic [SW-1:0]       w_mul_a;
    logic [EPW-1:0]      w_mul_b;
    logic [MW-1:0]       w_prod;
    logic                w_need_div;
    logic [WSW-1:0]      w_dividend;
    logic [DVW-1:0]      w_divisor;
    logic [SW-1:0]       w_direct;
    logic                w_div_start;
    logic                w_div_done;
    logic [SW-1:0]       w_quot;
    logic                w_out_free;

    always_comb begin
        w_per_ext = CW'(r_period);
        if (w_per_ext == '0) begin
            p_eff = EPW'(1);
        end else if (w_per_ext > CW'(MAX_PERIOD)) begin
            p_eff = EPW'(MAX_PERIOD);
        end else begin
            p_eff = w_per_ext[EPW-1:0];
        end
    end

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_cfg_hit  = i_cfg_we && (i_cfg_idx == REG_PERIOD || i_cfg_idx == REG_METHOD);
    assign w_full_now = (r_seen >= p_eff);
    assign w_out_free = !r_ovalid || m_axis_tready;

    // oldest entry sits p places behind the write pointer
    always_comb begin
        w_wp_ext = IW'(r_wr_pos);
        if (w_wp_ext >= IW'(p_eff)) begin
            w_idx_ext = w_wp_ext - IW'(p_eff);
        end else begin
            w_idx_ext = w_wp_ext + IW'(MAX_PERIOD) - IW'(p_eff);
        end
        w_rd_idx = w_idx_ext[AW-1:0];
        n_wr_pos = (r_wr_pos == AW'(MAX_PERIOD - 1)) ? '0 : r_wr_pos + AW'(1);
    end

    // shared multiplier: weight times sample, then the second product of the step
    always_comb begin
        if (r_state == S_RD) begin
            w_mul_a = r_x;
            w_mul_b = w_full_now ? p_eff : r_seen + EPW'(1);
        end else if (r_method == METH_LWMA) begin
            w_mul_a = SW'(p_eff) + SW'(1);
            w_mul_b = p_eff;
        end else begin
            w_mul_a = r_last;
            w_mul_b = p_eff - EPW'(1);
        end
        w_prod = MW'(w_mul_a) * MW'(w_mul_b);
    end

    always_comb begin
        w_need_div = 1'b0;
        w_dividend = WSW'(r_run);
        w_divisor  = DVW'(p_eff);
        w_direct   = '0;
        unique case (r_method)
            METH_SMA: begin
                w_need_div = r_valid;
            end
            METH_EMA: begin
                w_need_div = !r_empty;
                w_direct   = r_x;
                w_dividend = WSW'({r_x, 1'b0}) + WSW'(r_prod);
                w_divisor  = DVW'(p_eff) + DVW'(1);
            end
            METH_SMMA: begin
                w_need_div = r_valid;
                if (r_full) begin
                    w_dividend = WSW'(r_prod) + WSW'(r_x);
                end
            end
            METH_LWMA: begin
                w_need_div = r_valid;
                w_dividend = r_wsum;
                w_divisor  = DVW'(r_prod >> 1);
            end
            default: begin
                w_need_div = 1'b0;
            end
        endcase
    end

    assign w_div_start = (r_state == S_PREP) && w_need_div;

    maf_div #(
        .DIVIDEND_W (WSW),
        .DIVISOR_W  (DVW),
        .QUOT_W     (SW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // sample window, read before write at the same edge
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_win[r_wr_pos] <= r_x;
            r_oldest        <= r_win[w_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_period <= PERIOD_RST;
            r_method <= METHOD_RST;
            r_wr_pos <= '0;
            r_seen   <= '0;
            r_run    <= '0;
            r_wsum   <= '0;
            r_last   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_cfg_hit) begin
                if (i_cfg_idx == REG_PERIOD) begin
                    r_period <= i_cfg_data[PERIOD_W-1:0];
                end else begin
                    r_method <= i_cfg_data[METHOD_W-1:0];
                end
            end

            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_cfg_hit || (w_accept && s_axis_tuser)) begin
                        r_seen <= '0;
                        r_run  <= '0;
                        r_wsum <= '0;
                        r_last <= '0;
                    end
                    if (w_accept) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_wr_pos <= n_wr_pos;
                    r_state  <= S_UPD;
                end
                S_UPD: begin
                    if (r_full) begin
                        r_seen <= p_eff;
                        r_wsum <= r_wsum - WSW'(r_run) + WSW'(r_prod);
                        r_run  <= r_run - RSW'(r_oldest) + RSW'(r_x);
                    end else begin
                        r_seen <= r_seen + EPW'(1);
                        r_wsum <= r_wsum + WSW'(r_prod);
                        r_run  <= r_run + RSW'(r_x);
                    end
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_state <= w_need_div ? S_DIV : S_DONE;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_last   <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x <= s_axis_tdata[SW-1:0];
        end
        if (r_state == S_RD || r_state == S_UPD) begin
            r_prod <= w_prod;
        end
        if (r_state == S_RD) begin
            r_full  <= w_full_now;
            r_empty <= (r_seen == '0);
        end
        if (r_state == S_UPD) begin
            r_valid <= r_full || ((r_seen + EPW'(1)) >= p_eff);
        end
        if (r_state == S_PREP) begin
            r_res     <= w_direct;
            r_res_vld <= (r_method == METH_EMA) || r_valid;
        end
        if (r_state == S_DIV && w_div_done) begin
            r_res <= w_quot;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_odata <= OUT_W'(r_res);
            r_ovld  <= r_res_vld;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ovld;

    a_seen_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= p_eff)
        else $error("sample count above period");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_RD))
        else $error("transfer did not start the sequence");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (m_axis_tvalid && r_state == S_IDLE))
        else $error("result not handed to output register");

    a_ema_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_method == METH_EMA) |-> r_res_vld)
        else $error("exponential result not flagged valid");

endmodule

`default_nettype wire

@@ sim/moving_average_filter_checker.sv @@
// moving average filter checker: watches both streams, predicts each average, compares
module moving_average_filter_checker
    import maf_pkg::*;
(
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]                    i_cfg_data,
    input  logic                                     s_axis_tvalid,
    input  logic                                     s_axis_tready,
    input  logic [((SAMPLE_WIDTH_DEF+7)/8)*8-1:0]    s_axis_tdata,   // sample
    input  logic                                     s_axis_tuser,   // restart
    input  logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    input  logic [OUT_W-1:0]                         m_axis_tdata,   // average
    input  logic                                     m_axis_tuser,   // valid_res
    output int                                       o_fail_count,
    output int                                       o_pending,
    output int                                       o_compared
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW           = SAMPLE_WIDTH_DEF;
    localparam int WINDOW_DEPTH = MAX_PERIOD_DEF;
    localparam int MAX_REPORTS  = 40;

    typedef struct packed {
        logic [OUT_W-1:0] average;
        logic             valid_res;
    } avg_result_t;

    avg_result_t         expected_avgs[$];
    logic [SW-1:0]       price_ring [WINDOW_DEPTH];
    int unsigned         ring_pos      = 0;
    logic [63:0]         window_sum    = '0;
    logic [63:0]         weighted_sum  = '0;
    logic [SW-1:0]       prev_average  = '0;
    int unsigned         samples_held  = 0;
    logic [PERIOD_W-1:0] cur_period    = PERIOD_RST;
    logic [METHOD_W-1:0] cur_method    = METHOD_RST;
    int                  fail_total    = 0;
    int                  compare_total = 0;

    function automatic void clear_history();
        window_sum   = '0;
        weighted_sum = '0;
        prev_average = '0;
        samples_held = 0;
    endfunction

    function automatic avg_result_t advance_average(input logic [SW-1:0] price,
                                                    input logic restart);
        int unsigned span;
        logic [63:0] span_w;
        logic [63:0] x;
        logic [63:0] oldest;
        logic [63:0] avg;
        bit          was_empty;
        bit          was_full;
        bit          full_now;
        avg_result_t res;
        if (restart)
            clear_history();
        if (cur_period == '0)
            span = 1;
        else if (cur_period > WINDOW_DEPTH)
            span = WINDOW_DEPTH;
        else
            span = cur_period;
        span_w    = 64'(span);
        x         = 64'(price);
        oldest    = '0;
        was_empty = (samples_held == 0);
        was_full  = (samples_held >= span);
        if (was_full)
            oldest = 64'(price_ring[(ring_pos + WINDOW_DEPTH - span) % WINDOW_DEPTH]);
        price_ring[ring_pos] = price;
        ring_pos = (ring_pos + 1) % WINDOW_DEPTH;
        if (was_full) begin
            weighted_sum = weighted_sum - window_sum + span_w * x;
            window_sum   = window_sum - oldest + x;
        end else begin
            samples_held++;
            weighted_sum = weighted_sum + 64'(samples_held) * x;
            window_sum   = window_sum + x;
        end
        full_now = (samples_held >= span);
        case (cur_method)
            METH_SMA: begin
                avg = full_now ? window_sum / span_w : '0;
            end
            METH_EMA: begin
                if (was_empty)
                    avg = x;
                else
                    avg = (2 * x + (span_w - 1) * 64'(prev_average)) / (span_w + 1);
                full_now = 1'b1;
            end
            METH_SMMA: begin
                if (was_full)
                    avg = (64'(prev_average) * (span_w - 1) + x) / span_w;
                else
                    avg = full_now ? window_sum / span_w : '0;
            end
            default: begin
                avg = full_now ? weighted_sum / ((span_w * (span_w + 1)) / 2) : '0;
            end
        endcase
        prev_average  = avg[SW-1:0];
        res.average   = avg[OUT_W-1:0];
        res.valid_res = full_now;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (fail_total < MAX_REPORTS)
            $display("mismatch at %0t ns, result %0d: %s got 0x%0h, expected 0x%0h",
                     $time, compare_total, what, got, want);
        fail_total++;
    endtask

    always @(posedge i_clk) begin : track
        avg_result_t want;
        if (!i_rst_n) begin
            cur_period = PERIOD_RST;
            cur_method = METHOD_RST;
            ring_pos   = 0;
            clear_history();
            expected_avgs.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_PERIOD)
                    cur_period = i_cfg_data[PERIOD_W-1:0];
                else if (i_cfg_idx == REG_METHOD)
                    cur_method = i_cfg_data[METHOD_W-1:0];
                clear_history();
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_avgs.push_back(advance_average(s_axis_tdata[SW-1:0], s_axis_tuser));
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_avgs.size() == 0) begin
                    report_mismatch("unexpected transfer, average", m_axis_tdata, 0);
                end else begin
                    want = expected_avgs.pop_front();
                    if (m_axis_tdata !== want.average)
                        report_mismatch("average", m_axis_tdata, want.average);
                    if (m_axis_tuser !== want.valid_res)
                        report_mismatch("valid_res", m_axis_tuser, want.valid_res);
                    compare_total++;
                end
            end
        end
        o_pending    <= expected_avgs.size();
        o_fail_count <= fail_total;
        o_compared   <= compare_total;
    end

endmodule

@@ sim/moving_average_filter_tb.sv @@
// moving average filter testbench top: clock, reset, stimulus, receiver and verdict
module moving_average_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import maf_pkg::*;

    localparam int SW           = SAMPLE_WIDTH_DEF;
    localparam int DATA_W       = ((SW + 7) / 8) * 8;
    localparam int RESET_CYCLES = 9;
    localparam int SETTLE       = 4;
    localparam int TAIL_CYCLES  = 64;
    localparam int HOLD_CYCLES  = 700;
    localparam int RANDOM_ITEMS = 1130;
    localparam int CYCLE_LIMIT  = 1_000_000;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = REG_PERIOD;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata  = '0;   // sample
    logic                  s_axis_tuser  = 1'b0; // restart
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;         // average
    logic                  m_axis_tuser;         // valid_res

    int fail_count;
    int pending;
    int compared;
    int cycle_count  = 0;
    int samples_sent = 0;
    int writes_done  = 0;
    bit idling       = 1'b1;
    bit hold_req     = 1'b0;

    moving_average_filter u_top (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
    );

    moving_average_filter_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_compared   (compared)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d averages outstanding",
                     cycle_count, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(idling && $urandom_range(99) < 9);
            end
        end
    end

    function automatic logic [SW-1:0] pick_sample();
        logic [SW-1:0] val;
        case ($urandom_range(7))
            0:       val = '1;
            1:       val = '0;
            2:       val = SW'($urandom_range(255));
            3:       val = '1 - SW'($urandom_range(1023));
            default: val = SW'($urandom());
        endcase
        return val;
    endfunction

    function automatic logic [PERIOD_W-1:0] pick_period();
        logic [PERIOD_W-1:0] per;
        case ($urandom_range(9))
            0:       per = '0;
            1, 2:    per = PERIOD_W'($urandom_range(24, 9));
            default: per = PERIOD_W'($urandom_range(8, 1));
        endcase
        return per;
    endfunction

    task automatic send_sample(input logic [SW-1:0] price, input logic restart);
        while (idling && $urandom_range(99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DATA_W'(price);
        s_axis_tuser  <= restart;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        samples_sent++;
    endtask

    // registers change only with the filter drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        writes_done++;
    endtask

    task automatic set_mode(input logic [PERIOD_W-1:0] per, input logic [METHOD_W-1:0] meth);
        write_reg(REG_PERIOD, CFG_DATA_W'(per));
        write_reg(REG_METHOD, CFG_DATA_W'(meth));
    endtask

    initial begin
        int                  random_sent;
        int                  rnd_phase;
        int                  span;
        int                  phase_items;
        int                  k;
        logic [PERIOD_W-1:0] per;
        logic [METHOD_W-1:0] meth;
        logic [CFG_DATA_W-1:0] meth_data;
        logic                restart;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // period zero behaves as one
        set_mode('0, METH_SMA);
        send_sample('1, 1'b0);
        send_sample('0, 1'b0);
        send_sample(SW'(1), 1'b0);
        // exponential seeding and restart
        set_mode(PERIOD_W'(2), METH_EMA);
        send_sample('1, 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b1);
        send_sample(SW'(1), 1'b0);
        // smoothed: zero until the window fills, then seeded with the mean
        set_mode(PERIOD_W'(3), METH_SMMA);
        send_sample('1, 1'b0);
        send_sample('1, 1'b0);
        send_sample('1 - SW'(1), 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b1);
        set_mode(PERIOD_W'(2), METH_LWMA);
        send_sample('1, 1'b0);
        send_sample('1, 1'b0);
        send_sample('0, 1'b0);
        // period above the window depth is clamped
        set_mode('1, METH_EMA);
        send_sample('1, 1'b0);
        send_sample('0, 1'b0);
        set_mode(PERIOD_W'(MAX_PERIOD_DEF), METH_LWMA);
        send_sample('1, 1'b0);
        send_sample('1, 1'b0);
        // rewriting the same method still clears history
        write_reg(REG_METHOD, CFG_DATA_W'(METH_LWMA));
        send_sample('1, 1'b0);

        random_sent = 0;
        rnd_phase   = 0;
        while (random_sent < RANDOM_ITEMS) begin
            idling <= !(random_sent >= 450 && random_sent < 650);
            if (rnd_phase == 3) begin
                // deep window, near-full scale weighted sum
                per         = '1;
                meth        = METH_LWMA;
                phase_items = 280;
                set_mode(per, meth);
            end else begin
                per         = pick_period();
                meth        = METHOD_W'($urandom_range(3));
                span        = (per == '0) ? 1 : int'(per);
                phase_items = $urandom_range(2 * span + 24, span + 3);
                meth_data   = CFG_DATA_W'(meth);
                if ($urandom_range(1))
                    meth_data[CFG_DATA_W-1:METHOD_W] = (CFG_DATA_W-METHOD_W)'($urandom());
                case ($urandom_range(3))
                    0: begin
                        write_reg(REG_PERIOD, CFG_DATA_W'(per));
                        write_reg(REG_METHOD, meth_data);
                    end
                    1: begin
                        write_reg(REG_METHOD, meth_data);
                        write_reg(REG_PERIOD, CFG_DATA_W'(per));
                    end
                    2: write_reg(REG_PERIOD, CFG_DATA_W'(per));
                    default: write_reg(REG_METHOD, meth_data);
                endcase
            end
            for (k = 0; k < phase_items; k++) begin
                if (random_sent == 40)
                    hold_req <= 1'b1;
                restart = (rnd_phase != 3) && ($urandom_range(99) < 4);
                send_sample(pick_sample(), restart);
                random_sent++;
            end
            rnd_phase++;
        end

        s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d samples across %0d register writes: all four methods,",
                 samples_sent, writes_done);
        $display("periods 0 to 511 with clamping, restarts, and %0d averages compared",
                 compared);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/maf_pkg.sv
hw/rtl/maf_div.sv
hw/rtl/moving_average_filter.sv
sim/moving_average_filter_checker.sv
sim/moving_average_filter_tb.sv
